[hw/rtl/assert_macros.svh]
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define GRMD_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define GRMD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/grmd_pkg.sv]
package grmd_pkg;

    localparam int MAP_DIM     = 64;
    localparam int TILE_PIXELS = 32;
    localparam int ANGLE_BITS  = 12;

    localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
    localparam int IDX_W   = ANGLE_BITS - 1;
    localparam int MAG_W   = 15;
    localparam int SIN_W   = 16;

    localparam int FRAC_BITS    = 15;
    localparam int ORIGIN_FRAC  = 8;
    localparam int ORIGIN_SHIFT = FRAC_BITS - ORIGIN_FRAC;
    localparam int ORIGIN_W     = 19;
    localparam int CELL_W       = 6;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = 13;
    localparam int DIST_W       = 21;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    localparam int POS_W = $clog2(2 ** (ORIGIN_W + ORIGIN_SHIFT)
                                  + (TILE_PIXELS / 2) * 2 ** FRAC_BITS
                                  + (2 ** STEP_W) * 2 ** (SIN_W - 2)) + 1;
    localparam int HALF_TILE_POS = (TILE_PIXELS / 2) * 2 ** FRAC_BITS;
    localparam int PX_W  = POS_W - 1 - FRAC_BITS;
    localparam int LIM_W = $clog2(MAP_DIM * TILE_PIXELS + 1);
    localparam int CMP_W = (PX_W > LIM_W) ? PX_W : LIM_W;
    localparam int CW    = $clog2(MAP_DIM);

    localparam int PROD_W      = STEP_W + 1 + SIN_W;
    localparam int ROUND_SHIFT = 7;
    localparam int ROUND_HALF  = 2 ** (ROUND_SHIFT - 1);

    localparam int Q_DEPTH = 2;

    localparam logic [CFG_W-1:0] MAP_SIZE_RESET = CFG_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam longint unsigned THETA_RND = 64'd1 << (ANGLE_BITS - 2);
    localparam longint unsigned ONE_Q30   = 64'd1 << 30;

    typedef struct packed {
        logic                   action;
        logic [CELL_W-1:0]      cell_x;
        logic [CELL_W-1:0]      cell_y;
        logic                   cell_wall;
        logic [ORIGIN_W-1:0]    origin_x;
        logic [ORIGIN_W-1:0]    origin_y;
        logic [ANGLE_BITS-1:0]  ray_dir;
        logic [ANGLE_BITS-1:0]  view_dir;
    } in_item_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [STEP_W-1:0]        step_count;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } map_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } rom_ref_t;

    typedef struct packed {
        logic                    kind;
        logic [CW-1:0]           wx;
        logic [CW-1:0]           wy;
        logic                    wval;
        logic                    wen;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        rom_ref_t                cos_ref;
        rom_ref_t                sin_ref;
        rom_ref_t                corr_ref;
    } op_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef logic [MAG_W-1:0] sine_tab_t [0:QUARTER];

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t       tab;
        longint unsigned theta;
        longint unsigned th2;
        longint unsigned term;
        longint          sum;
        for (int a = 0; a <= QUARTER; a++) begin
            theta = (64'(a) * PI_Q30 + THETA_RND) >> (ANGLE_BITS - 1);
            th2   = (theta * theta) >> 30;
            term  = theta;
            sum   = longint'(theta);
            for (int k = 1; k <= 12; k++) begin
                term = (term * th2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    sum = sum - longint'(term);
                end
                else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(ONE_Q30)) begin
                sum = longint'(ONE_Q30);
            end
            tab[a] = MAG_W'((64'(sum) + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    function automatic rom_ref_t sine_ref(input logic [ANGLE_BITS-1:0] ang);
        rom_ref_t              rr;
        logic [ANGLE_BITS-3:0] r;
        r      = ang[ANGLE_BITS-3:0];
        rr.idx = ang[ANGLE_BITS-2] ? (IDX_W'(QUARTER) - IDX_W'(r)) : IDX_W'(r);
        rr.neg = ang[ANGLE_BITS-1];
        return rr;
    endfunction

endpackage

[hw/rtl/grmd_sine_rom.sv]
module grmd_sine_rom (
    input  logic                        clk,
    input  logic [grmd_pkg::IDX_W-1:0]  addr,
    output logic [grmd_pkg::MAG_W-1:0]  data
);
    import grmd_pkg::*;

    logic [MAG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SINE_TAB[addr];
    end

    assign data = data_reg;

endmodule

[hw/rtl/grmd_front.sv]
module grmd_front (
    input  logic                    start,
    output logic                    busy,
    input  grmd_pkg::in_item_t      request,
    input  logic                    q_full,
    input  grmd_pkg::back_status_t  bstat,
    output logic                    push,
    output grmd_pkg::op_t           push_op
);
    import grmd_pkg::*;

    logic [ANGLE_BITS-1:0] corr_ang;

    assign busy     = q_full | bstat.clearing;
    assign push     = start & ~busy;
    assign corr_ang = request.ray_dir - request.view_dir;

    always_comb
    begin
        push_op.kind     = request.action;
        push_op.wx       = CW'(request.cell_x);
        push_op.wy       = CW'(request.cell_y);
        push_op.wval     = request.cell_wall;
        push_op.wen      = (int'(request.cell_x) < MAP_DIM) && (int'(request.cell_y) < MAP_DIM);
        push_op.pos_x    = (POS_W'(request.origin_x) << ORIGIN_SHIFT) + POS_W'(HALF_TILE_POS);
        push_op.pos_y    = (POS_W'(request.origin_y) << ORIGIN_SHIFT) + POS_W'(HALF_TILE_POS);
        push_op.cos_ref  = sine_ref(request.ray_dir + ANGLE_BITS'(QUARTER));
        push_op.sin_ref  = sine_ref(request.ray_dir);
        push_op.corr_ref = sine_ref(corr_ang + ANGLE_BITS'(QUARTER));
    end

endmodule

[hw/rtl/grmd_queue.sv]
module grmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  grmd_pkg::op_t  push_op,
    output logic           full,
    output logic           head_valid,
    output grmd_pkg::op_t  head_op,
    input  logic           pop
);
    import grmd_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    op_t              slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign full       = (count_reg == CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

endmodule

[hw/rtl/grmd_back.sv]
module grmd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  grmd_pkg::map_cfg_t      cfg,
    input  logic                    q_valid,
    input  grmd_pkg::op_t           q_op,
    output logic                    q_pop,
    output grmd_pkg::back_status_t  bstat,
    output logic                    done,
    output grmd_pkg::out_item_t     result
);
    import grmd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_MARCH = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic          oob;
        logic [CW-1:0] tile;
    } probe_t;

    localparam logic [1:0] SLOT_COS   = 2'd0;
    localparam logic [1:0] SLOT_SIN   = 2'd1;
    localparam logic [1:0] SLOT_CORR  = 2'd2;
    localparam logic [1:0] FETCH_LAST = 2'd3;

    function automatic probe_t axis_probe(input logic signed [POS_W-1:0] pos,
                                          input logic [LIM_W-1:0] lim);
        probe_t          p;
        logic            near_zero;
        logic [PX_W-1:0] px;
        near_zero = (&pos[POS_W-1:FRAC_BITS]) && (|pos[FRAC_BITS-1:0]);
        px        = pos[POS_W-1] ? '0 : pos[FRAC_BITS+PX_W-1:FRAC_BITS];
        p.oob     = (pos[POS_W-1] && !near_zero) || (CMP_W'(px) >= CMP_W'(lim));
        p.tile    = CW'(px / TILE_PIXELS);
        return p;
    endfunction

    state_t                   state_reg;
    state_t                   state_next;
    logic [1:0]               fetch_cnt_reg;
    logic [1:0]               fetch_cnt_next;
    logic                     chk_valid_reg;
    logic                     chk_valid_next;
    logic                     done_reg;
    logic                     clr_active_reg;
    logic                     clr_active_next;
    logic [CW-1:0]            clr_x_reg;
    logic [CW-1:0]            clr_x_next;
    logic [CW-1:0]            clr_y_reg;
    logic [CW-1:0]            clr_y_next;

    op_t                      op_reg;
    logic signed [SIN_W-1:0]  step_x_reg;
    logic signed [SIN_W-1:0]  step_y_reg;
    logic signed [SIN_W-1:0]  corr_reg;
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic                     chk_oob_reg;
    logic                     chk_max_reg;
    logic [STEP_W-1:0]        chk_steps_reg;
    logic [STEP_W-1:0]        hit_steps_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [LIM_W-1:0]         lim_x_reg;
    logic [LIM_W-1:0]         lim_y_reg;
    logic                     map_rd_reg;
    out_item_t                result_reg;

    logic                     map_mem [MAP_DIM][MAP_DIM];

    logic                     hit;
    logic                     map_wr;
    logic [IDX_W-1:0]         rom_addr;
    logic [MAG_W-1:0]         rom_data;
    logic                     cap_neg;
    logic signed [SIN_W-1:0]  cap_mag;
    logic signed [SIN_W-1:0]  cap_val;
    probe_t                   probe_x;
    probe_t                   probe_y;
    logic signed [PROD_W-1:0] steps_ext;
    logic signed [PROD_W-1:0] corr_ext;
    logic signed [PROD_W-1:0] rounded;
    int                       eff_w;
    int                       eff_h;

    grmd_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign q_pop  = q_valid && (state_reg == ST_IDLE) && !clr_active_reg;
    assign map_wr = q_pop && (q_op.kind == ACT_WRITE) && q_op.wen;
    assign hit    = chk_valid_reg && (chk_oob_reg || chk_max_reg || map_rd_reg);

    assign probe_x = axis_probe(pos_x_reg, lim_x_reg);
    assign probe_y = axis_probe(pos_y_reg, lim_y_reg);

    assign eff_w = (int'(cfg.width) > MAP_DIM) ? MAP_DIM : int'(cfg.width);
    assign eff_h = (int'(cfg.height) > MAP_DIM) ? MAP_DIM : int'(cfg.height);

    assign steps_ext = PROD_W'($signed({1'b0, hit_steps_reg}));
    assign corr_ext  = PROD_W'(corr_reg);
    assign rounded   = prod_reg + PROD_W'(ROUND_HALF);

    always_comb
    begin
        case (fetch_cnt_reg)
            SLOT_COS:  rom_addr = op_reg.cos_ref.idx;
            SLOT_SIN:  rom_addr = op_reg.sin_ref.idx;
            default:   rom_addr = op_reg.corr_ref.idx;
        endcase
        case (fetch_cnt_reg)
            SLOT_SIN:  cap_neg = op_reg.cos_ref.neg;
            SLOT_CORR: cap_neg = op_reg.sin_ref.neg;
            default:   cap_neg = op_reg.corr_ref.neg;
        endcase
        cap_mag = $signed({1'b0, rom_data});
        cap_val = cap_neg ? -cap_mag : cap_mag;
    end

    always_comb
    begin
        state_next     = state_reg;
        fetch_cnt_next = fetch_cnt_reg;
        chk_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                fetch_cnt_next = SLOT_COS;
                if (q_pop && (q_op.kind == ACT_CAST))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                fetch_cnt_next = fetch_cnt_reg + 1'b1;
                if (fetch_cnt_reg == FETCH_LAST)
                begin
                    state_next = ST_MARCH;
                end
            end
            ST_MARCH:
            begin
                if (hit)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    chk_valid_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_x_next      = clr_x_reg;
        clr_y_next      = clr_y_reg;
        if (clr_active_reg)
        begin
            if (clr_x_reg == CW'(MAP_DIM - 1))
            begin
                clr_x_next = '0;
                if (clr_y_reg == CW'(MAP_DIM - 1))
                begin
                    clr_active_next = 1'b0;
                end
                else
                begin
                    clr_y_next = clr_y_reg + 1'b1;
                end
            end
            else
            begin
                clr_x_next = clr_x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fetch_cnt_reg  <= SLOT_COS;
            chk_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_x_reg      <= '0;
            clr_y_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fetch_cnt_reg  <= fetch_cnt_next;
            chk_valid_reg  <= chk_valid_next;
            done_reg       <= (state_reg == ST_OUT);
            clr_active_reg <= clr_active_next;
            clr_x_reg      <= clr_x_next;
            clr_y_reg      <= clr_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_x_reg <= LIM_W'(eff_w * TILE_PIXELS);
        lim_y_reg <= LIM_W'(eff_h * TILE_PIXELS);
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        if (state_reg == ST_FETCH)
        begin
            case (fetch_cnt_reg)
                SLOT_SIN:   step_x_reg <= cap_val;
                SLOT_CORR:  step_y_reg <= cap_val;
                FETCH_LAST: corr_reg   <= cap_val;
                default:
                begin
                end
            endcase
        end
        // Start the march, then advance one half pixel a cycle until a hit or the step cap
        if ((state_reg == ST_FETCH) && (fetch_cnt_reg == FETCH_LAST))
        begin
            pos_x_reg <= op_reg.pos_x;
            pos_y_reg <= op_reg.pos_y;
            steps_reg <= '0;
        end
        else if ((state_reg == ST_MARCH) && (steps_reg != STEP_MAX))
        begin
            pos_x_reg <= pos_x_reg + POS_W'(step_x_reg);
            pos_y_reg <= pos_y_reg + POS_W'(step_y_reg);
            steps_reg <= steps_reg + 1'b1;
        end
        chk_oob_reg   <= probe_x.oob | probe_y.oob;
        chk_max_reg   <= (steps_reg == STEP_MAX);
        chk_steps_reg <= steps_reg;
        if (hit)
        begin
            hit_steps_reg <= chk_steps_reg;
        end
        prod_reg <= steps_ext * corr_ext;
        if (state_reg == ST_OUT)
        begin
            result_reg.distance   <= rounded[DIST_W+ROUND_SHIFT-1:ROUND_SHIFT];
            result_reg.step_count <= hit_steps_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            map_mem[clr_y_reg][clr_x_reg] <= 1'b0;
        end
        else if (map_wr)
        begin
            map_mem[q_op.wy][q_op.wx] <= q_op.wval;
        end
        map_rd_reg <= map_mem[probe_y.tile][probe_x.tile];
    end

    assign bstat.clearing = clr_active_reg;
    assign done           = done_reg;
    assign result         = result_reg;

endmodule

[hw/rtl/grid_ray_march_distance.sv]
// Channel     | Signals                              | Transaction when
// ------------+--------------------------------------+---------------------------------
// command     | start, busy, request                 | start high, busy low
// result      | done, result                         | done high (one cycle, no stall)
// config      | cfg_valid, cfg_ready, cfg_index/data | cfg_valid and cfg_ready high
//
// A map write is done in the back end when it leaves the queue and gives no result.
// A cast reads the cosine, sine and correction terms from the sine table, marches
// (one half-pixel step a cycle, map read registered) until a hit, then scales and rounds.
// After reset the map is cleared one cell a cycle, all MAP_DIM * MAP_DIM cells,
// with busy high; configuration writes are taken meanwhile.
// busy rises when the two-entry command queue is full; results cannot be held off.
module grid_ray_march_distance (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  grmd_pkg::in_item_t                 request,
    output logic                               done,
    output grmd_pkg::out_item_t                result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [grmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grmd_pkg::CFG_W-1:0]         cfg_data
);
    import grmd_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    map_cfg_t         map_cfg;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             push;
    op_t              push_op;
    op_t              head_op;
    back_status_t     bstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= MAP_SIZE_RESET;
            height_reg <= MAP_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  width_reg  <= cfg_data;
                REG_MAP_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign map_cfg.width  = width_reg;
    assign map_cfg.height = height_reg;

    grmd_front u_front (
        .start   (start),
        .busy    (busy),
        .request (request),
        .q_full  (q_full),
        .bstat   (bstat),
        .push    (push),
        .push_op (push_op)
    );

    grmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .head_valid (q_valid),
        .head_op    (head_op),
        .pop        (q_pop)
    );

    grmd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (map_cfg),
        .q_valid (q_valid),
        .q_op    (head_op),
        .q_pop   (q_pop),
        .bstat   (bstat),
        .done    (done),
        .result  (result)
    );

endmodule

[hw/rtl/grmd_checker.sv]
`include "assert_macros.svh"

module grmd_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 busy,
    input  logic                 done,
    input  grmd_pkg::out_item_t  result
);
    import grmd_pkg::*;

    `GRMD_ASSERT_ALWAYS(a_busy_in_reset, clk, !rst_n |=> busy, "busy low after reset")
    `GRMD_ASSERT_ON(a_done_spaced, clk, rst_n, done |=> !done, "results in consecutive cycles")
    `GRMD_ASSERT_ON(a_dist_upper, clk, rst_n, done |-> int'(result.distance) <= 128 * int'(result.step_count), "distance above half the step count")
    `GRMD_ASSERT_ON(a_dist_lower, clk, rst_n, done |-> int'(result.distance) >= -128 * int'(result.step_count), "distance below minus half the step count")

endmodule

bind grid_ray_march_distance grmd_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result)
);
